// ----- hw/rtl/vqdcm_pkg.sv -----
// shared types, codes and constants of the virtqueue descriptor chain manager
`timescale 1ns / 1ps

package vqdcm_pkg;

    // defaults of the top-level parameters
    localparam int DESC_COUNT_DEF    = 8;
    localparam int HEADER_STRIDE_DEF = 16;
    localparam int STATUS_STRIDE_DEF = 16;

    // longest walk of a free item, in records
    localparam int MAX_RECORDS = 8;
    localparam int CNT_W       = $clog2(MAX_RECORDS);

    // input item kinds (tuser)
    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_FREE   = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FEW  = 2'd1;
    localparam logic [1:0] ERR_FREE = 2'd2;

    // descriptor flags
    localparam logic [1:0] FLAG_NEXT      = 2'b01;
    localparam logic [1:0] FLAG_DEV_WRITE = 2'b10;

    // descriptor lengths
    localparam logic [16:0] HEADER_LEN = 17'd16;
    localparam logic [16:0] STATUS_LEN = 17'd1;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  CFG_HEADER_BASE   = 2'd0;
    localparam logic [1:0]  CFG_STATUS_BASE   = 2'd1;
    localparam logic [1:0]  CFG_BLOCK_BYTES   = 2'd2;
    localparam logic [1:0]  CFG_SECTORS_PER_B = 2'd3;

    // configuration reset values
    localparam logic [16:0] BLOCK_BYTES_RST = 17'd1024;
    localparam logic [7:0]  SPB_RST         = 8'd2;

    // input item payload
    localparam int IN_FIELDS_W = 1 + 32 + 64 + 3;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // one result record, desc_index in the lowest bits
    typedef struct packed {
        logic [1:0]  error;
        logic [2:0]  avail_head;
        logic [2:0]  ring_slot;
        logic [38:0] sector;
        logic        req_type;
        logic [2:0]  desc_next;
        logic [1:0]  desc_flags;
        logic [16:0] desc_len;
        logic [63:0] desc_addr;
        logic [2:0]  desc_index;
    } t_rec;

    localparam int REC_W       = $bits(t_rec);
    localparam int OUT_TDATA_W = ((REC_W + 7) / 8) * 8;

    // operation of the shared multiply-add unit: a + x * y
    typedef struct packed {
        logic [63:0] a;
        logic [31:0] x;
        logic [7:0]  y;
    } t_mac_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_CALC,
        ST_SUB_OUT,
        ST_SUB_ERR,
        ST_FR_CHECK,
        ST_FR_OUT,
        ST_FR_ERR
    } t_state;

endpackage

// ----- hw/rtl/virtqueue_descriptor_chain_manager.sv -----
// top level: descriptor free map, chain links, submit and free sequencer
`timescale 1ns / 1ps

// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: is_write, block_number, data_addr,
//                                                head_index; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: one descriptor record; tlast: last
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// a submit runs from acceptance to its last record as 3 free-map scans, three operations on
// the shared multiply-add unit, then 3 records; a submit that finds too few free gives one
// error record
// a free item checks and releases each descriptor walked and emits its record, taking the
// next link from the registered read of the chain link memory
// reset (i_rst_n low, synchronous) frees every descriptor and zeroes the ring producer
// a stalled output holds the sequencer in its record state; input is taken only when idle

module virtqueue_descriptor_chain_manager #(
    parameter int DESC_COUNT    = vqdcm_pkg::DESC_COUNT_DEF,
    parameter int HEADER_STRIDE = vqdcm_pkg::HEADER_STRIDE_DEF,
    parameter int STATUS_STRIDE = vqdcm_pkg::STATUS_STRIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] is_write, [32:1] block_number, [96:33] data_addr, [99:97] head_index
    input  logic [vqdcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] kind
    input  logic                                s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] desc_index, [66:3] desc_addr, [83:67] desc_len, [85:84] desc_flags,
    // [88:86] desc_next, [89] req_type, [128:90] sector, [131:129] ring_slot,
    // [134:132] avail_head, [136:135] error
    output logic [vqdcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vqdcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    // descriptor index width, never below the 3-bit record fields
    localparam int IW   = (DESC_COUNT > 8) ? $clog2(DESC_COUNT) : 3;
    localparam int SPAN = 1 << IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(DESC_COUNT - 1);
    localparam logic [vqdcm_pkg::CNT_W-1:0] CNT_LAST = vqdcm_pkg::CNT_W'(
        vqdcm_pkg::MAX_RECORDS - 1);

    // lowest set bit: {found, index}
    function automatic logic [IW:0] find_first(input logic [DESC_COUNT-1:0] v);
        logic [IW:0] res;
        res = '0;
        for (int i = DESC_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, IW'(i)};
            end
        end
        return res;
    endfunction

    // configuration
    logic [63:0] r_hdr_base;
    logic [63:0] r_stat_base;
    logic [16:0] r_blk_bytes;
    logic [7:0]  r_spb;

    // control state
    vqdcm_pkg::t_state             r_state, n_state;
    logic [2:0]                    r_step, n_step;
    logic [vqdcm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]                 r_cur, n_cur;
    logic [DESC_COUNT-1:0]         r_free, n_free;
    logic [DESC_COUNT-1:0]         r_picked, n_picked;
    logic [15:0]                   r_producer, n_producer;
    logic [IW-1:0]                 r_slot, n_slot;
    logic                          r_out_valid, n_out_valid;

    // item payload
    logic                          r_is_write;
    logic [31:0]                   r_blk_num;
    logic [63:0]                   r_data_addr;
    logic [IW-1:0]                 r_pick [3];
    logic [63:0]                   r_hdr_addr;
    logic [38:0]                   r_sector;
    logic [63:0]                   r_stat_addr;
    logic [IW-1:0]                 r_sub_slot;
    vqdcm_pkg::t_rec               r_out;
    logic                          r_out_last;

    // chain link memory: {has_next, next}
    logic [IW:0]                   r_chain [SPAN];
    logic [IW:0]                   r_rd;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_load;
    vqdcm_pkg::t_rec               w_rec;
    logic                          w_rec_last;
    logic [IW:0]                   w_ff;
    logic [SPAN-1:0]               w_free_pad;
    logic                          w_bad;
    logic                          w_we;
    logic [IW-1:0]                 w_waddr;
    logic [IW:0]                   w_wdata;
    logic                          w_rd_en;
    vqdcm_pkg::t_mac_op            w_op;
    logic [63:0]                   w_sum;

    assign s_axis_tready = (r_state == vqdcm_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(vqdcm_pkg::OUT_TDATA_W - vqdcm_pkg::REC_W)'(0), r_out};
    assign m_axis_tlast  = r_out_last;

    assign w_ff = find_first(r_free & ~r_picked);

    // descriptors past the end read as free, so they take the error path
    always_comb begin
        w_free_pad                 = '1;
        w_free_pad[DESC_COUNT-1:0] = r_free;
    end
    assign w_bad = w_free_pad[r_cur];

    vqdcm_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_sum (w_sum)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_free      = r_free;
        n_picked    = r_picked;
        n_producer  = r_producer;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_load      = 1'b0;
        w_rec       = '0;
        w_rec_last  = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_pick[0];
        w_wdata     = '0;
        w_rd_en     = 1'b0;
        w_op        = '0;

        case (r_state)
            vqdcm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == vqdcm_pkg::KIND_FREE) begin
                        n_cur   = IW'(s_axis_tdata[99:97]);
                        n_cnt   = '0;
                        n_state = vqdcm_pkg::ST_FR_CHECK;
                    end else begin
                        n_picked = '0;
                        n_step   = '0;
                        n_state  = vqdcm_pkg::ST_PICK;
                    end
                end
            end

            // one free descriptor per cycle, lowest first
            vqdcm_pkg::ST_PICK: begin
                if (!w_ff[IW]) begin
                    n_state = vqdcm_pkg::ST_SUB_ERR;
                end else begin
                    n_picked[w_ff[IW-1:0]] = 1'b1;
                    if (r_step == 3'd2) begin
                        n_step  = '0;
                        n_state = vqdcm_pkg::ST_CALC;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end

            // issue header address, sector, status address; collect each from the registered multiply-add result
            vqdcm_pkg::ST_CALC: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        w_op = '{a: r_hdr_base, x: 32'(r_pick[0]), y: 8'(HEADER_STRIDE)};
                        w_we    = 1'b1;
                        w_waddr = r_pick[0];
                        w_wdata = {1'b1, r_pick[1]};
                        n_free[r_pick[0]] = 1'b0;
                        n_free[r_pick[1]] = 1'b0;
                        n_free[r_pick[2]] = 1'b0;
                    end
                    3'd1: begin
                        w_op = '{a: 64'd0, x: r_blk_num, y: r_spb};
                        w_we    = 1'b1;
                        w_waddr = r_pick[1];
                        w_wdata = {1'b1, r_pick[2]};
                    end
                    3'd2: begin
                        w_op = '{a: r_stat_base, x: 32'(r_pick[0]), y: 8'(STATUS_STRIDE)};
                        w_we    = 1'b1;
                        w_waddr = r_pick[2];
                        w_wdata = '0;
                    end
                    3'd3: begin
                    end
                    3'd4: begin
                        // ring slot tracks producer mod count, also across the 16-bit wrap
                        n_producer = r_producer + 16'd1;
                        if (r_producer == 16'hffff || r_slot == LAST_IDX) begin
                            n_slot = '0;
                        end else begin
                            n_slot = r_slot + IW'(1);
                        end
                        n_step  = '0;
                        n_state = vqdcm_pkg::ST_SUB_OUT;
                    end
                    default: begin
                        n_step = '0;
                    end
                endcase
            end

            // header, data and status records
            vqdcm_pkg::ST_SUB_OUT: begin
                w_rec.desc_index = r_pick[r_step[1:0]][2:0];
                w_rec.ring_slot  = r_sub_slot[2:0];
                w_rec.avail_head = r_pick[0][2:0];
                case (r_step)
                    3'd0: begin
                        w_rec.desc_addr  = r_hdr_addr;
                        w_rec.desc_len   = vqdcm_pkg::HEADER_LEN;
                        w_rec.desc_flags = vqdcm_pkg::FLAG_NEXT;
                        w_rec.desc_next  = r_pick[1][2:0];
                        w_rec.req_type   = r_is_write;
                        w_rec.sector     = r_sector;
                    end
                    3'd1: begin
                        w_rec.desc_addr  = r_data_addr;
                        w_rec.desc_len   = r_blk_bytes;
                        w_rec.desc_flags = r_is_write ? vqdcm_pkg::FLAG_NEXT
                                         : (vqdcm_pkg::FLAG_NEXT | vqdcm_pkg::FLAG_DEV_WRITE);
                        w_rec.desc_next  = r_pick[2][2:0];
                    end
                    default: begin
                        w_rec.desc_addr  = r_stat_addr;
                        w_rec.desc_len   = vqdcm_pkg::STATUS_LEN;
                        w_rec.desc_flags = vqdcm_pkg::FLAG_DEV_WRITE;
                        w_rec_last       = 1'b1;
                    end
                endcase
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_step == 3'd2) begin
                        n_step  = '0;
                        n_state = vqdcm_pkg::ST_IDLE;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end

            // too few free: nothing changes
            vqdcm_pkg::ST_SUB_ERR: begin
                w_rec.error = vqdcm_pkg::ERR_FEW;
                w_rec_last  = 1'b1;
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = vqdcm_pkg::ST_IDLE;
                end
            end

            // check the descriptor, release it and fetch its link
            vqdcm_pkg::ST_FR_CHECK: begin
                if (w_bad) begin
                    n_state = vqdcm_pkg::ST_FR_ERR;
                end else begin
                    w_rd_en       = 1'b1;
                    n_free[r_cur] = 1'b1;
                    n_state       = vqdcm_pkg::ST_FR_OUT;
                end
            end

            // link stays in r_rd while the output stalls; stale links are never read
            // because a descriptor is read only after a submit wrote it
            vqdcm_pkg::ST_FR_OUT: begin
                w_rec.desc_index = r_cur[2:0];
                w_rec_last       = !r_rd[IW] || (r_cnt == CNT_LAST);
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_rec_last) begin
                        n_state = vqdcm_pkg::ST_IDLE;
                    end else begin
                        n_cur   = r_rd[IW-1:0];
                        n_cnt   = r_cnt + vqdcm_pkg::CNT_W'(1);
                        n_state = vqdcm_pkg::ST_FR_CHECK;
                    end
                end
            end

            vqdcm_pkg::ST_FR_ERR: begin
                w_rec.desc_index = r_cur[2:0];
                w_rec.error      = vqdcm_pkg::ERR_FREE;
                w_rec_last       = 1'b1;
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = vqdcm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = vqdcm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vqdcm_pkg::ST_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_free      <= '1;
            r_picked    <= '0;
            r_producer  <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_cur       <= n_cur;
            r_free      <= n_free;
            r_picked    <= n_picked;
            r_producer  <= n_producer;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_base  <= '0;
            r_stat_base <= '0;
            r_blk_bytes <= vqdcm_pkg::BLOCK_BYTES_RST;
            r_spb       <= vqdcm_pkg::SPB_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                vqdcm_pkg::CFG_HEADER_BASE:   r_hdr_base  <= i_cfg_data;
                vqdcm_pkg::CFG_STATUS_BASE:   r_stat_base <= i_cfg_data;
                vqdcm_pkg::CFG_BLOCK_BYTES:   r_blk_bytes <= i_cfg_data[16:0];
                vqdcm_pkg::CFG_SECTORS_PER_B: r_spb       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_write  <= s_axis_tdata[0];
            r_blk_num   <= s_axis_tdata[32:1];
            r_data_addr <= s_axis_tdata[96:33];
        end
        if (r_state == vqdcm_pkg::ST_PICK && w_ff[IW]) begin
            r_pick[r_step[1:0]] <= w_ff[IW-1:0];
        end
        if (r_state == vqdcm_pkg::ST_CALC) begin
            if (r_step == 3'd2) begin
                r_hdr_addr <= w_sum;
            end
            if (r_step == 3'd3) begin
                r_sector <= w_sum[38:0];
            end
            if (r_step == 3'd4) begin
                r_stat_addr <= w_sum;
                r_sub_slot  <= r_slot;
            end
        end
        if (w_load) begin
            r_out      <= w_rec;
            r_out_last <= w_rec_last;
        end
    end

    // chain link memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_chain[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd <= r_chain[r_cur];
        end
    end

`ifndef SYNTHESIS
    // a committed submit takes exactly three descriptors
    a_submit_takes_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == vqdcm_pkg::ST_CALC && $past(r_step) == 3'd0)
        |-> ($countones(r_free) == $countones($past(r_free)) - 3))
        else $error("submit did not take three descriptors");

    // a walked descriptor is free afterwards
    a_walk_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vqdcm_pkg::ST_FR_CHECK && !w_bad) |=> w_free_pad[$past(r_cur)])
        else $error("walked descriptor not freed");

    // an error record always ends the item
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error != vqdcm_pkg::ERR_NONE) |-> r_out_last)
        else $error("error record without last");

    // ring slot stays inside the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_IDX)
        else $error("ring slot out of range");
`endif

endmodule

// ----- hw/rtl/vqdcm_mac.sv -----
// shared two-stage multiply-add unit: sum = a + x * y
`timescale 1ns / 1ps

module vqdcm_mac (
    input  logic                 i_clk,
    input  vqdcm_pkg::t_mac_op   i_op,
    output logic [63:0]          o_sum
);

    logic [39:0] r_prod;
    logic [63:0] r_a;
    logic [63:0] r_sum;

    // stage one multiplies, stage two adds
    always_ff @(posedge i_clk) begin
        r_prod <= {8'd0, i_op.x} * {32'd0, i_op.y};
        r_a    <= i_op.a;
        r_sum  <= r_a + {24'd0, r_prod};
    end

    assign o_sum = r_sum;

endmodule
